// ----- hw/rtl/rcfd_pkg.sv -----
// Package of shared types, constants and the CRC step function for the RC channel frame decoder.
`default_nettype none

package rcfd_pkg;

   localparam int CHANNEL_COUNT_DEFAULT = 16;
   localparam int CHANNEL_WIDTH_DEFAULT = 11;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 11;
   localparam int COUNT_W = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_ADDRESS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS_TYPE = 2'd1;

   localparam logic [BYTE_W-1:0] SYNC_ADDRESS_RESET  = 8'hC8;
   localparam logic [BYTE_W-1:0] CHANNELS_TYPE_RESET = 8'h16;
   localparam logic [BYTE_W-1:0] CRC_POLY            = 8'hD5;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_UNPACK,
      ST_LOAD,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic rd_en;
      logic load_byte;
      logic put_chan;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic crc_good;
      logic bits_enough;
      logic out_last;
   } status_type;

   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rcfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rcfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 22
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rcfd_ctrl.sv -----
// Controller state machine that sequences byte reception, unpacking and result handshakes.
`default_nettype none

module rcfd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rcfd_pkg::status_type status,
   output rcfd_pkg::cmd_type         cmd
);

   rcfd_pkg::state_type state_ff;
   rcfd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcfd_pkg::ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         rcfd_pkg::ST_RECV: begin
            req_ready     = 1'b1;
            cmd.take_byte = req_valid;
            if (req_valid && status.frame_end) begin
               state_in = status.crc_good ? rcfd_pkg::ST_UNPACK : rcfd_pkg::ST_WAIT;
            end
         end
         rcfd_pkg::ST_UNPACK: begin
            if (status.bits_enough) begin
               cmd.put_chan = 1'b1;
               state_in     = rcfd_pkg::ST_WAIT;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = rcfd_pkg::ST_LOAD;
            end
         end
         rcfd_pkg::ST_LOAD: begin
            cmd.load_byte = 1'b1;
            state_in      = rcfd_pkg::ST_UNPACK;
         end
         rcfd_pkg::ST_WAIT: begin
            // The final result of a frame leaves the framer at the hunt, so bytes may flow.
            // A CRC byte that would close another frame waits until that result is taken.
            rsp_valid     = 1'b1;
            req_ready     = status.out_last && !status.frame_end;
            cmd.take_byte = req_valid && status.out_last && !status.frame_end;
            if (rsp_ready) begin
               state_in = status.out_last ? rcfd_pkg::ST_RECV : rcfd_pkg::ST_UNPACK;
            end
         end
         default: begin
            state_in = rcfd_pkg::ST_RECV;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rcfd_datapath.sv -----
// Datapath with framing counter, CRC, payload store, bit unpacker, counters and result register.
`default_nettype none

module rcfd_datapath #(
   parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int CHANNEL_WIDTH = rcfd_pkg::CHANNEL_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [rcfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]         csr_data,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]         req_rx_byte,
   input  wire rcfd_pkg::cmd_type                   cmd,
   output rcfd_pkg::status_type                     status,
   output logic                                     rsp_status,
   output logic      [rcfd_pkg::INDEX_W-1:0]        rsp_channel_number,
   output logic      [rcfd_pkg::VALUE_W-1:0]        rsp_channel_value,
   output logic                                     rsp_last,
   output logic      [rcfd_pkg::COUNT_W-1:0]        rsp_good_frames,
   output logic      [rcfd_pkg::COUNT_W-1:0]        rsp_bad_crc_frames
);

   localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * CHANNEL_WIDTH + 7) / 8;
   localparam int FRAME_LAST    = PAYLOAD_BYTES + 3;
   localparam int FILL_W        = $clog2(FRAME_LAST + 1);
   localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
   localparam int CH_W          = $clog2(CHANNEL_COUNT);
   localparam int ACC_W         = CHANNEL_WIDTH + 8;
   localparam int BITS_W        = $clog2(ACC_W + 1);
   localparam logic [rcfd_pkg::BYTE_W-1:0] LENGTH_BYTE = rcfd_pkg::BYTE_W'(PAYLOAD_BYTES + 2);
   localparam logic [FILL_W-1:0] FILL_HUNT    = FILL_W'(0);
   localparam logic [FILL_W-1:0] FILL_LENGTH  = FILL_W'(1);
   localparam logic [FILL_W-1:0] FILL_TYPE    = FILL_W'(2);
   localparam logic [FILL_W-1:0] FILL_PAYLOAD = FILL_W'(3);
   localparam logic [FILL_W-1:0] FILL_CRC     = FILL_W'(FRAME_LAST);

   logic [rcfd_pkg::BYTE_W-1:0]  sync_ff;
   logic [rcfd_pkg::BYTE_W-1:0]  type_ff;
   logic [FILL_W-1:0]            fill_ff;
   logic [FILL_W-1:0]            fill_in;
   logic [rcfd_pkg::BYTE_W-1:0]  crc_ff;
   logic [rcfd_pkg::BYTE_W-1:0]  crc_in;
   logic [rcfd_pkg::COUNT_W-1:0] good_ff;
   logic [rcfd_pkg::COUNT_W-1:0] bad_ff;
   logic [ACC_W-1:0]             acc_ff;
   logic [BITS_W-1:0]            bits_ff;
   logic [ADDR_W-1:0]            rd_addr_ff;
   logic [CH_W-1:0]              ch_ff;
   logic                         out_status_ff;
   logic [rcfd_pkg::INDEX_W-1:0] out_index_ff;
   logic [rcfd_pkg::VALUE_W-1:0] out_value_ff;
   logic                         out_last_ff;
   logic                         store_we;
   logic [FILL_W-1:0]            store_offset;
   logic [rcfd_pkg::BYTE_W-1:0]  rd_data;
   logic                         sync_hit;
   logic                         frame_end;
   logic                         crc_good;

   assign sync_hit     = req_rx_byte == sync_ff;
   assign frame_end    = fill_ff == FILL_CRC;
   assign crc_good     = req_rx_byte == crc_ff;
   assign store_offset = fill_ff - FILL_PAYLOAD;

   always_comb begin
      fill_in  = fill_ff;
      crc_in   = crc_ff;
      store_we = 1'b0;
      if (fill_ff == FILL_HUNT) begin
         fill_in = sync_hit ? FILL_LENGTH : FILL_HUNT;
      end else if (fill_ff == FILL_LENGTH) begin
         if (req_rx_byte == LENGTH_BYTE) begin
            fill_in = FILL_TYPE;
         end else begin
            fill_in = sync_hit ? FILL_LENGTH : FILL_HUNT;
         end
      end else if (fill_ff == FILL_TYPE) begin
         if (req_rx_byte == type_ff) begin
            fill_in = FILL_PAYLOAD;
            crc_in  = rcfd_pkg::crc8_step('0, req_rx_byte);
         end else begin
            fill_in = sync_hit ? FILL_LENGTH : FILL_HUNT;
         end
      end else if (frame_end) begin
         fill_in = FILL_HUNT;
      end else begin
         fill_in  = fill_ff + FILL_W'(1);
         crc_in   = rcfd_pkg::crc8_step(crc_ff, req_rx_byte);
         store_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= rcfd_pkg::SYNC_ADDRESS_RESET;
         type_ff <= rcfd_pkg::CHANNELS_TYPE_RESET;
         fill_ff <= FILL_HUNT;
         good_ff <= '0;
         bad_ff  <= '0;
      end else begin
         if (csr_we && csr_index == rcfd_pkg::CSR_SYNC_ADDRESS) begin
            sync_ff <= csr_data;
         end
         if (csr_we && csr_index == rcfd_pkg::CSR_CHANNELS_TYPE) begin
            type_ff <= csr_data;
         end
         if (cmd.take_byte) begin
            fill_ff <= fill_in;
            if (frame_end && crc_good && good_ff != '1) begin
               good_ff <= good_ff + rcfd_pkg::COUNT_W'(1);
            end
            if (frame_end && !crc_good && bad_ff != '1) begin
               bad_ff <= bad_ff + rcfd_pkg::COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         crc_ff <= crc_in;
      end
      if (cmd.take_byte && frame_end) begin
         acc_ff     <= '0;
         bits_ff    <= '0;
         rd_addr_ff <= '0;
         ch_ff      <= '0;
         if (!crc_good) begin
            out_status_ff <= 1'b0;
            out_index_ff  <= '0;
            out_value_ff  <= '0;
            out_last_ff   <= 1'b1;
         end
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
      end
      if (cmd.load_byte) begin
         acc_ff  <= acc_ff | (ACC_W'(rd_data) << bits_ff);
         bits_ff <= bits_ff + BITS_W'(8);
      end
      if (cmd.put_chan) begin
         acc_ff        <= acc_ff >> CHANNEL_WIDTH;
         bits_ff       <= bits_ff - BITS_W'(CHANNEL_WIDTH);
         ch_ff         <= ch_ff + CH_W'(1);
         out_status_ff <= 1'b1;
         out_index_ff  <= rcfd_pkg::INDEX_W'(ch_ff);
         out_value_ff  <= rcfd_pkg::VALUE_W'(acc_ff[CHANNEL_WIDTH-1:0]);
         out_last_ff   <= ch_ff == CH_W'(CHANNEL_COUNT - 1);
      end
   end

   rcfd_ram #(
      .WIDTH(rcfd_pkg::BYTE_W),
      .DEPTH(PAYLOAD_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.take_byte && store_we),
      .wr_addr(store_offset[ADDR_W-1:0]),
      .wr_data(req_rx_byte),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      status             = '0;
      status.frame_end   = frame_end;
      status.crc_good    = crc_good;
      status.bits_enough = bits_ff >= BITS_W'(CHANNEL_WIDTH);
      status.out_last    = out_last_ff;
   end

   assign rsp_status         = out_status_ff;
   assign rsp_channel_number = out_index_ff;
   assign rsp_channel_value  = out_value_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_good_frames    = good_ff;
   assign rsp_bad_crc_frames = bad_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rc_channel_frame_decoder.sv -----
// Top level of the RC channel frame decoder: controller, datapath and checks.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_rx_byte
//   rsp      out        rsp_valid/rsp_ready    status, number, value, last, both frame counters
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// After the CRC byte a bad frame gives one result in the next cycle; a good frame gives one
// result per channel, each registered once the payload bytes it needs have been read from
// the store, and held there until the handshake takes it.
// Reset is synchronous and clears the framer, the counters and the registers to defaults.
// A stalled result holds the block; during the final result of a frame bytes are still taken,
// except a CRC byte that would close another frame.
`default_nettype none

module rc_channel_frame_decoder #(
   parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int CHANNEL_WIDTH = rcfd_pkg::CHANNEL_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_status,
   output logic      [rcfd_pkg::INDEX_W-1:0]     rsp_channel_number,
   output logic      [rcfd_pkg::VALUE_W-1:0]     rsp_channel_value,
   output logic                                  rsp_last,
   output logic      [rcfd_pkg::COUNT_W-1:0]     rsp_good_frames,
   output logic      [rcfd_pkg::COUNT_W-1:0]     rsp_bad_crc_frames,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rcfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rcfd_pkg::BYTE_W-1:0]      csr_data
);

   rcfd_pkg::cmd_type    cmd;
   rcfd_pkg::status_type status;

   assign csr_ready = 1'b1;

   rcfd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   rcfd_datapath #(
      .CHANNEL_COUNT(CHANNEL_COUNT),
      .CHANNEL_WIDTH(CHANNEL_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_status        (rsp_status),
      .rsp_channel_number(rsp_channel_number),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last),
      .rsp_good_frames   (rsp_good_frames),
      .rsp_bad_crc_frames(rsp_bad_crc_frames)
   );

   // A request may only be taken alongside a pending result when that result ends its frame.
   assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> rsp_last)
      else $error("request taken while a frame still has results pending");

   // A CRC error result is a single, final result with empty channel fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status) |-> (rsp_last && rsp_channel_number == '0 &&
                                      rsp_channel_value == '0))
      else $error("CRC error result is malformed");

   // The frame counters never decrease.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (rsp_good_frames >= $past(rsp_good_frames) &&
                rsp_bad_crc_frames >= $past(rsp_bad_crc_frames)))
      else $error("frame counter decreased");

   // The counters only move when a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> ($stable(rsp_good_frames) && $stable(rsp_bad_crc_frames)))
      else $error("frame counter changed without a request");

endmodule

`default_nettype wire
